/* rtl/m3i_pkg.sv */
package m3i_pkg;

  // Cofactor (difference of two 32x32 products) and determinant widths.
  localparam int COF_W = 65;
  localparam int DET_W = 98;
  // Top quotient bit examined by the divider; a set bit here means saturation.
  localparam int QB = 33;

  // Pipeline depths of the sub-units, in registers.
  localparam int COF_LAT = 2;
  localparam int DET_LAT = 3;
  localparam int DIV_LAT = QB + 2;

  typedef logic signed [31:0] elem_t;
  typedef elem_t [8:0] mat_t;            // index is column*3 + row
  typedef logic signed [COF_W-1:0] cof_t;
  typedef cof_t [8:0] cofv_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef struct packed {
    elem_t in_c0r0;
    elem_t in_c0r1;
    elem_t in_c0r2;
    elem_t in_c1r0;
    elem_t in_c1r1;
    elem_t in_c1r2;
    elem_t in_c2r0;
    elem_t in_c2r1;
    elem_t in_c2r2;
  } req_t;

  typedef struct packed {
    elem_t out_c0r0;
    elem_t out_c0r1;
    elem_t out_c0r2;
    elem_t out_c1r0;
    elem_t out_c1r1;
    elem_t out_c1r2;
    elem_t out_c2r0;
    elem_t out_c2r1;
    elem_t out_c2r2;
    logic  singular;
    logic  overflow;
  } res_t;

  typedef struct packed {
    elem_t q;
    logic  ovf;
  } lane_res_t;

  function automatic mat_t to_mat(req_t r);
    return {r.in_c2r2, r.in_c2r1, r.in_c2r0, r.in_c1r2, r.in_c1r1, r.in_c1r0,
            r.in_c0r2, r.in_c0r1, r.in_c0r0};
  endfunction

  function automatic res_t to_res(mat_t m, logic sing, logic ovf);
    res_t r;
    r.out_c0r0 = m[0];
    r.out_c0r1 = m[1];
    r.out_c0r2 = m[2];
    r.out_c1r0 = m[3];
    r.out_c1r1 = m[4];
    r.out_c1r2 = m[5];
    r.out_c2r0 = m[6];
    r.out_c2r1 = m[7];
    r.out_c2r2 = m[8];
    r.singular = sing;
    r.overflow = ovf;
    return r;
  endfunction

endpackage

/* rtl/m3i_cof.sv */
// One cofactor lane: a*b - c*d over two registered stages.
module m3i_cof (
  input  logic            clk,
  input  logic            en,
  input  m3i_pkg::elem_t  a,
  input  m3i_pkg::elem_t  b,
  input  m3i_pkg::elem_t  c,
  input  m3i_pkg::elem_t  d,
  output m3i_pkg::cof_t   cof
);

  logic signed [63:0] p0;
  logic signed [63:0] p1;

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= $signed(a) * $signed(b);
      p1  <= $signed(c) * $signed(d);
      cof <= m3i_pkg::cof_t'(p0) - m3i_pkg::cof_t'(p1);
    end
  end

endmodule

/* rtl/m3i_det.sv */
// Determinant as row 0 dotted with its cofactors; each 65x32 product is
// split into a 33x32 high part and a 32x32 low part.
module m3i_det (
  input  logic                clk,
  input  logic                en,
  input  m3i_pkg::cof_t [2:0] cof,
  input  m3i_pkg::elem_t [2:0] e,
  output m3i_pkg::det_t       det
);

  logic signed [64:0]  lo_p [3];
  logic signed [64:0]  hi_p [3];
  m3i_pkg::det_t       t [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        lo_p[j] <= $signed({1'b0, cof[j][31:0]}) * $signed(e[j]);
        hi_p[j] <= $signed(cof[j][m3i_pkg::COF_W-1:32]) * $signed(e[j]);
        t[j]    <= (m3i_pkg::det_t'(hi_p[j]) <<< 32) + m3i_pkg::det_t'(lo_p[j]);
      end
      det <= t[0] + t[1] + t[2];
    end
  end

endmodule

/* rtl/m3i_div.sv */
// Signed divide lane: restoring division, one quotient bit per stage,
// then sign and saturation to 32 bits.
module m3i_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  m3i_pkg::cof_t         cof,
  input  m3i_pkg::det_t         det,
  output m3i_pkg::lane_res_t    res
);

  localparam int NUM_W = m3i_pkg::COF_W + 2 * FRAC_BITS;
  localparam int DW    = m3i_pkg::DET_W + m3i_pkg::QB;
  localparam int RW    = ((NUM_W > DW) ? NUM_W : DW) + 1;
  localparam int NS    = m3i_pkg::QB + 1;

  logic [m3i_pkg::COF_W-1:0] na;
  logic [m3i_pkg::DET_W-1:0] dmag;

  logic [RW-1:0]             rr [NS+1];
  logic [m3i_pkg::DET_W-1:0] dd [NS+1];
  logic                      nn [NS+1];
  logic [NS-1:0]             qq [NS+1];

  assign na   = cof[m3i_pkg::COF_W-1] ? m3i_pkg::COF_W'(-cof) : m3i_pkg::COF_W'(cof);
  assign dmag = det[m3i_pkg::DET_W-1] ? m3i_pkg::DET_W'(-det) : m3i_pkg::DET_W'(det);

  always_ff @(posedge clk) begin
    if (en) begin
      rr[0] <= RW'(na) << (2 * FRAC_BITS);
      dd[0] <= dmag;
      nn[0] <= cof[m3i_pkg::COF_W-1] ^ det[m3i_pkg::DET_W-1];
      qq[0] <= '0;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam int BIT = m3i_pkg::QB - s;
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = RW'(dd[s]) << BIT;
    assign ge = rr[s] >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rr[s+1] <= ge ? rr[s] - sh : rr[s];
        dd[s+1] <= dd[s];
        nn[s+1] <= nn[s];
        qq[s+1] <= qq[s] | (NS'(ge) << BIT);
      end
    end
  end

  logic [NS-1:0] lim;
  logic          ovf;
  logic [31:0]   v;

  assign lim = nn[NS] ? (NS'(1) << 31) : ((NS'(1) << 31) - NS'(1));
  assign ovf = qq[NS] > lim;
  assign v   = ovf ? lim[31:0] : qq[NS][31:0];

  assign res.q   = nn[NS] ? -v : v;
  assign res.ovf = ovf;

endmodule

/* rtl/matrix3_inverse.sv */
// 3x3 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// One matrix request is accepted every cycle unless a result is stalled; each
// result passes the input register, 2 cofactor stages, 3 determinant
// stages, then the restoring divider in each of the nine lanes (an entry
// register and 34 stages, one quotient bit per stage), and last the output
// register; FRAC_BITS does not change this path. A singular matrix
// (determinant zero, or its magnitude below the threshold written through
// cfg_data, in fixed-point units) comes back unchanged with singular set;
// otherwise each element of the adjugate is divided by the determinant,
// truncated toward zero, and saturated, with overflow set if any element
// saturated. A stalled result holds the whole pipeline; one more request is
// held in a skid register meanwhile.
module matrix3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  m3i_pkg::req_t  req,
  output logic           res_valid,
  input  logic           res_ready,
  output m3i_pkg::res_t  res,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_data
);

  localparam int ST_COF  = 1 + m3i_pkg::COF_LAT;
  localparam int ST_DET  = ST_COF + m3i_pkg::DET_LAT;
  localparam int ST_SING = ST_DET + 1;
  localparam int ST_LANE = ST_DET + m3i_pkg::DIV_LAT;

  // Threshold register.
  logic [31:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 32'd1;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  // Global advance: the pipeline moves whenever the output register is free.
  logic adv;
  assign adv = !res_valid || res_ready;

  // Skid register: take a request while the pipeline is held.
  logic          skid_v;
  m3i_pkg::req_t skid;
  m3i_pkg::req_t src;
  logic          src_v;

  assign req_ready = !skid_v;
  assign src       = skid_v ? skid : req;
  assign src_v     = skid_v || req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (adv) begin
      skid_v <= 1'b0;
    end else if (req_valid && req_ready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && req_valid && req_ready) begin
      skid <= req;
    end
  end

  // Valid and matrix delay lines; the matrix is kept for the singular bypass.
  logic           v  [1:ST_LANE];
  m3i_pkg::mat_t  md [1:ST_LANE];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= ST_LANE; i++) v[i] <= 1'b0;
    end else if (adv) begin
      v[1] <= src_v;
      for (int i = 2; i <= ST_LANE; i++) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      md[1] <= m3i_pkg::to_mat(src);
      for (int i = 2; i <= ST_LANE; i++) md[i] <= md[i-1];
    end
  end

  // Cofactor lanes: lane k*3+j is element j of row_a x row_b, with
  // (a,b) = (1,2), (2,0), (0,1) for adjugate column k. Row r element c is
  // matrix index c*3+r.
  m3i_pkg::cofv_t cof_now;

  for (genvar k = 0; k < 3; k++) begin : g_col
    for (genvar j = 0; j < 3; j++) begin : g_row
      localparam int RA = (k == 0) ? 1 : ((k == 1) ? 2 : 0);
      localparam int RB = (k == 0) ? 2 : ((k == 1) ? 0 : 1);
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;

      m3i_cof u_cof (
        .clk (clk),
        .en  (adv),
        .a   (md[1][J1*3+RA]),
        .b   (md[1][J2*3+RB]),
        .c   (md[1][J2*3+RA]),
        .d   (md[1][J1*3+RB]),
        .cof (cof_now[k*3+j])
      );
    end
  end

  // Determinant from row 0 and the first adjugate column.
  m3i_pkg::det_t det;

  m3i_det u_det (
    .clk (clk),
    .en  (adv),
    .cof ({cof_now[2], cof_now[1], cof_now[0]}),
    .e   ({md[ST_COF][6], md[ST_COF][3], md[ST_COF][0]}),
    .det (det)
  );

  // Hold the cofactors until the determinant is ready.
  m3i_pkg::cofv_t cd [1:m3i_pkg::DET_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      cd[1] <= cof_now;
      for (int i = 2; i <= m3i_pkg::DET_LAT; i++) cd[i] <= cd[i-1];
    end
  end

  // Singular decision, then carry it to the end of the divider.
  m3i_pkg::det_t mag;
  m3i_pkg::det_t lim;
  logic          sing_now;
  logic          sing_line [ST_SING:ST_LANE];

  assign mag      = det[m3i_pkg::DET_W-1] ? -det : det;
  assign lim      = m3i_pkg::det_t'(thr) << (2 * FRAC_BITS);
  assign sing_now = (det == '0) || (mag < lim);

  always_ff @(posedge clk) begin
    if (adv) begin
      sing_line[ST_SING] <= sing_now;
      for (int i = ST_SING + 1; i <= ST_LANE; i++) sing_line[i] <= sing_line[i-1];
    end
  end

  // Divide lanes.
  m3i_pkg::lane_res_t lr [9];

  for (genvar l = 0; l < 9; l++) begin : g_div
    m3i_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .cof (cd[m3i_pkg::DET_LAT][l]),
      .det (det),
      .res (lr[l])
    );
  end

  // Merge: pick bypass or quotients, and gather the saturation flags.
  m3i_pkg::mat_t q_mat;
  logic          any_ovf;

  always_comb begin
    any_ovf = 1'b0;
    for (int l = 0; l < 9; l++) begin
      q_mat[l] = lr[l].q;
      any_ovf  = any_ovf | lr[l].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v[ST_LANE];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= sing_line[ST_LANE] ? m3i_pkg::to_res(md[ST_LANE], 1'b1, 1'b0)
                                : m3i_pkg::to_res(q_mat, 1'b0, any_ovf);
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.singular && res.overflow))
    else $error("singular and overflow both set");

  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !adv) |=> skid_v)
    else $error("request taken during stall was not held");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_v && !adv) |=> (skid_v && $stable(skid)))
    else $error("skid register lost its request");

  a_zero_det: assert property (@(posedge clk) disable iff (rst)
    (adv && v[ST_DET] && det == '0) |=> sing_line[ST_SING])
    else $error("zero determinant not flagged singular");

endmodule
